// File: rtl/core/sic_pkg.sv
package sic_pkg;

  localparam int unsigned CoordFieldW = 16;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 60;
  localparam int unsigned ThrW        = 32;
  localparam int unsigned FracBits    = 16;

  localparam logic [CfgIdxW-1:0] CfgFRow0     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFRow1     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgFRow2     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 3'd3;

  localparam logic [ThrW-1:0] ThrReset = 32'h0001_0000;

  typedef struct packed {
    logic signed [CoordFieldW-1:0] point1_x;
    logic signed [CoordFieldW-1:0] point1_y;
    logic signed [CoordFieldW-1:0] point2_x;
    logic signed [CoordFieldW-1:0] point2_y;
    logic                          last_pair;
  } sic_in_t;

  typedef struct packed {
    logic inlier;
    logic degenerate;
    logic last_result;
  } sic_out_t;

endpackage

// File: rtl/core/sic_front.sv
module sic_front #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned COEF_WIDTH  = 20
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  sic_pkg::sic_in_t                          in_data_i,
  input  logic [3*COEF_WIDTH-1:0]                   f_row0_i,
  input  logic [3*COEF_WIDTH-1:0]                   f_row1_i,
  input  logic [3*COEF_WIDTH-1:0]                   f_row2_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic signed [COEF_WIDTH+COORD_WIDTH:0]    out_fx0_o,
  output logic signed [COEF_WIDTH+COORD_WIDTH:0]    out_fx1_o,
  output logic signed [COEF_WIDTH+COORD_WIDTH:0]    out_fx2_o,
  output logic signed [COEF_WIDTH+COORD_WIDTH:0]    out_ft0_o,
  output logic signed [COEF_WIDTH+COORD_WIDTH:0]    out_ft1_o,
  output logic signed [COORD_WIDTH-1:0]             out_x2_o,
  output logic signed [COORD_WIDTH-1:0]             out_y2_o,
  output logic                                      out_last_o
);

  localparam int unsigned PW  = COEF_WIDTH + COORD_WIDTH;
  localparam int unsigned FXW = PW + 1;

  logic signed [COORD_WIDTH-1:0] x1, y1, x2, y2;
  logic signed [COEF_WIDTH-1:0]  a00, a01, a02, a10, a11, a12, a20, a21, a22;

  logic                          s1_v_q, s2_v_q;
  logic                          adv1, adv2;
  logic signed [PW-1:0]          s1_p_d [10];
  logic signed [PW-1:0]          s1_p_q [10];
  logic signed [COORD_WIDTH-1:0] s1_x2_q, s1_y2_q;
  logic                          s1_last_q;
  logic signed [FXW-1:0]         s2_fx0_d, s2_fx1_d, s2_fx2_d, s2_ft0_d, s2_ft1_d;
  logic signed [FXW-1:0]         s2_fx0_q, s2_fx1_q, s2_fx2_q, s2_ft0_q, s2_ft1_q;
  logic signed [COORD_WIDTH-1:0] s2_x2_q, s2_y2_q;
  logic                          s2_last_q;

  assign x1 = COORD_WIDTH'($unsigned(in_data_i.point1_x));
  assign y1 = COORD_WIDTH'($unsigned(in_data_i.point1_y));
  assign x2 = COORD_WIDTH'($unsigned(in_data_i.point2_x));
  assign y2 = COORD_WIDTH'($unsigned(in_data_i.point2_y));

  assign a00 = $signed(f_row0_i[0 +: COEF_WIDTH]);
  assign a01 = $signed(f_row0_i[COEF_WIDTH +: COEF_WIDTH]);
  assign a02 = $signed(f_row0_i[2*COEF_WIDTH +: COEF_WIDTH]);
  assign a10 = $signed(f_row1_i[0 +: COEF_WIDTH]);
  assign a11 = $signed(f_row1_i[COEF_WIDTH +: COEF_WIDTH]);
  assign a12 = $signed(f_row1_i[2*COEF_WIDTH +: COEF_WIDTH]);
  assign a20 = $signed(f_row2_i[0 +: COEF_WIDTH]);
  assign a21 = $signed(f_row2_i[COEF_WIDTH +: COEF_WIDTH]);
  assign a22 = $signed(f_row2_i[2*COEF_WIDTH +: COEF_WIDTH]);

  assign adv2       = !s2_v_q || !out_stall_i;
  assign adv1       = !s1_v_q || adv2;
  assign in_stall_o = !adv1;

  always_comb begin
    s1_p_d[0] = PW'(a00) * PW'(x1);
    s1_p_d[1] = PW'(a01) * PW'(y1);
    s1_p_d[2] = PW'(a10) * PW'(x1);
    s1_p_d[3] = PW'(a11) * PW'(y1);
    s1_p_d[4] = PW'(a20) * PW'(x1);
    s1_p_d[5] = PW'(a21) * PW'(y1);
    s1_p_d[6] = PW'(a00) * PW'(x2);
    s1_p_d[7] = PW'(a10) * PW'(y2);
    s1_p_d[8] = PW'(a01) * PW'(x2);
    s1_p_d[9] = PW'(a11) * PW'(y2);
  end

  always_comb begin
    s2_fx0_d = FXW'(s1_p_q[0]) + FXW'(s1_p_q[1]) + FXW'(a02);
    s2_fx1_d = FXW'(s1_p_q[2]) + FXW'(s1_p_q[3]) + FXW'(a12);
    s2_fx2_d = FXW'(s1_p_q[4]) + FXW'(s1_p_q[5]) + FXW'(a22);
    s2_ft0_d = FXW'(s1_p_q[6]) + FXW'(s1_p_q[7]) + FXW'(a20);
    s2_ft1_d = FXW'(s1_p_q[8]) + FXW'(s1_p_q[9]) + FXW'(a21);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_v_q <= in_valid_i;
      end
      if (adv2) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      s1_p_q    <= s1_p_d;
      s1_x2_q   <= x2;
      s1_y2_q   <= y2;
      s1_last_q <= in_data_i.last_pair;
    end
    if (adv2 && s1_v_q) begin
      s2_fx0_q  <= s2_fx0_d;
      s2_fx1_q  <= s2_fx1_d;
      s2_fx2_q  <= s2_fx2_d;
      s2_ft0_q  <= s2_ft0_d;
      s2_ft1_q  <= s2_ft1_d;
      s2_x2_q   <= s1_x2_q;
      s2_y2_q   <= s1_y2_q;
      s2_last_q <= s1_last_q;
    end
  end

  assign out_valid_o = s2_v_q;
  assign out_fx0_o   = s2_fx0_q;
  assign out_fx1_o   = s2_fx1_q;
  assign out_fx2_o   = s2_fx2_q;
  assign out_ft0_o   = s2_ft0_q;
  assign out_ft1_o   = s2_ft1_q;
  assign out_x2_o    = s2_x2_q;
  assign out_y2_o    = s2_y2_q;
  assign out_last_o  = s2_last_q;

endmodule

// File: rtl/core/sic_norm.sv
module sic_norm #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned COEF_WIDTH  = 20
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 in_valid_i,
  output logic                                                 in_stall_o,
  input  logic signed [COEF_WIDTH+COORD_WIDTH:0]               in_fx0_i,
  input  logic signed [COEF_WIDTH+COORD_WIDTH:0]               in_fx1_i,
  input  logic signed [COEF_WIDTH+COORD_WIDTH:0]               in_fx2_i,
  input  logic signed [COEF_WIDTH+COORD_WIDTH:0]               in_ft0_i,
  input  logic signed [COEF_WIDTH+COORD_WIDTH:0]               in_ft1_i,
  input  logic signed [COORD_WIDTH-1:0]                        in_x2_i,
  input  logic signed [COORD_WIDTH-1:0]                        in_y2_i,
  input  logic                                                 in_last_i,
  output logic                                                 out_valid_o,
  input  logic                                                 out_stall_i,
  output logic signed [2*COORD_WIDTH+COEF_WIDTH+1:0]           out_res_o,
  output logic [2*(COEF_WIDTH+COORD_WIDTH+1)-1:0]              out_sq_o [4],
  output logic                                                 out_last_o
);

  localparam int unsigned FXW = COEF_WIDTH + COORD_WIDTH + 1;
  localparam int unsigned H   = (FXW + 1) / 2;
  localparam int unsigned HW  = FXW - H;
  localparam int unsigned HHW = 2 * HW;
  localparam int unsigned HLW = FXW + 1;
  localparam int unsigned LLW = 2 * H;
  localparam int unsigned SQW = 2 * FXW;
  localparam int unsigned SSW = 2 * FXW + 1;
  localparam int unsigned PRW = COORD_WIDTH + FXW;
  localparam int unsigned RW  = PRW + 1;

  logic signed [FXW-1:0] sv [4];

  logic                  s3_v_q, s4_v_q;
  logic                  adv3, adv4;
  logic signed [HHW-1:0] s3_hh_d [4];
  logic signed [HHW-1:0] s3_hh_q [4];
  logic signed [HLW-1:0] s3_hl_d [4];
  logic signed [HLW-1:0] s3_hl_q [4];
  logic [LLW-1:0]        s3_ll_d [4];
  logic [LLW-1:0]        s3_ll_q [4];
  logic signed [PRW-1:0] s3_rp0_d, s3_rp1_d, s3_rp0_q, s3_rp1_q;
  logic signed [FXW-1:0] s3_fx2_q;
  logic                  s3_last_q;
  logic [SSW-1:0]        sq_full [4];
  logic [SQW-1:0]        s4_sq_d [4];
  logic [SQW-1:0]        s4_sq_q [4];
  logic signed [RW-1:0]  s4_res_d, s4_res_q;
  logic                  s4_last_q;

  assign sv[0] = in_fx0_i;
  assign sv[1] = in_fx1_i;
  assign sv[2] = in_ft0_i;
  assign sv[3] = in_ft1_i;

  assign adv4       = !s4_v_q || !out_stall_i;
  assign adv3       = !s3_v_q || adv4;
  assign in_stall_o = !adv3;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s3_hh_d[i] = HHW'($signed(sv[i][FXW-1:H])) * HHW'($signed(sv[i][FXW-1:H]));
      s3_hl_d[i] = HLW'($signed(sv[i][FXW-1:H])) * HLW'($signed({1'b0, sv[i][H-1:0]}));
      s3_ll_d[i] = LLW'(sv[i][H-1:0]) * LLW'(sv[i][H-1:0]);
    end
    s3_rp0_d = PRW'(in_x2_i) * PRW'(in_fx0_i);
    s3_rp1_d = PRW'(in_y2_i) * PRW'(in_fx1_i);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq_full[i] = (SSW'(s3_hh_q[i]) << (2 * H)) + (SSW'(s3_hl_q[i]) << (H + 1))
                 + SSW'(s3_ll_q[i]);
      s4_sq_d[i] = sq_full[i][SQW-1:0];
    end
    s4_res_d = RW'(s3_rp0_q) + RW'(s3_rp1_q) + RW'(s3_fx2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (adv3) begin
        s3_v_q <= in_valid_i;
      end
      if (adv4) begin
        s4_v_q <= s3_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && in_valid_i) begin
      s3_hh_q   <= s3_hh_d;
      s3_hl_q   <= s3_hl_d;
      s3_ll_q   <= s3_ll_d;
      s3_rp0_q  <= s3_rp0_d;
      s3_rp1_q  <= s3_rp1_d;
      s3_fx2_q  <= in_fx2_i;
      s3_last_q <= in_last_i;
    end
    if (adv4 && s3_v_q) begin
      s4_sq_q   <= s4_sq_d;
      s4_res_q  <= s4_res_d;
      s4_last_q <= s3_last_q;
    end
  end

  assign out_valid_o = s4_v_q;
  assign out_res_o   = s4_res_q;
  assign out_sq_o    = s4_sq_q;
  assign out_last_o  = s4_last_q;

endmodule

// File: rtl/core/sic_decide.sv
module sic_decide #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned COEF_WIDTH  = 20
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_stall_o,
  input  logic signed [2*COORD_WIDTH+COEF_WIDTH+1:0]  in_res_i,
  input  logic [2*(COEF_WIDTH+COORD_WIDTH+1)-1:0]     in_sq_i [4],
  input  logic                                        in_last_i,
  input  logic [sic_pkg::ThrW-1:0]                    thr_i,
  output logic                                        out_valid_o,
  input  logic                                        out_stall_i,
  output sic_pkg::sic_out_t                           out_data_o
);

  localparam int unsigned FXW  = COEF_WIDTH + COORD_WIDTH + 1;
  localparam int unsigned SQW  = 2 * FXW;
  localparam int unsigned DW   = SQW + 1;
  localparam int unsigned RW   = COORD_WIDTH + FXW + 1;
  localparam int unsigned RH   = (RW + 1) / 2;
  localparam int unsigned RHW  = RW - RH;
  localparam int unsigned RHHW = 2 * RHW;
  localparam int unsigned RHLW = RW + 1;
  localparam int unsigned RLLW = 2 * RH;
  localparam int unsigned RSW  = 2 * RW + 1;
  localparam int unsigned R2W  = 2 * RW;
  localparam int unsigned K    = (DW + 2) / 3;
  localparam int unsigned PKW  = sic_pkg::ThrW + K;
  localparam int unsigned TW   = sic_pkg::ThrW + DW;
  localparam int unsigned LW   = R2W + sic_pkg::FracBits;
  localparam int unsigned CMW  = (LW > TW) ? LW : TW;

  logic                   s5_v_q, s6_v_q, s7_v_q, out_v_q;
  logic                   adv5, adv6, adv7, adv8;

  logic [DW-1:0]          s5_den_d, s5_den_q;
  logic signed [RHHW-1:0] s5_rhh_d, s5_rhh_q;
  logic signed [RHLW-1:0] s5_rhl_d, s5_rhl_q;
  logic [RLLW-1:0]        s5_rll_d, s5_rll_q;
  logic                   s5_last_q;

  logic [RSW-1:0]         res2_full;
  logic [R2W-1:0]         s6_res2_q;
  logic [PKW-1:0]         s6_pc_d [3];
  logic [PKW-1:0]         s6_pc_q [3];
  logic                   s6_deg_q, s6_last_q;

  logic [TW-1:0]          s7_rhs_d, s7_rhs_q;
  logic [R2W-1:0]         s7_res2_q;
  logic                   s7_deg_q, s7_last_q;

  logic [CMW-1:0]         lhs, rhs;
  sic_pkg::sic_out_t      out_d, out_q;

  assign adv8       = !out_v_q || !out_stall_i;
  assign adv7       = !s7_v_q || adv8;
  assign adv6       = !s6_v_q || adv7;
  assign adv5       = !s5_v_q || adv6;
  assign in_stall_o = !adv5;

  always_comb begin
    s5_den_d = DW'(in_sq_i[0]) + DW'(in_sq_i[1]) + DW'(in_sq_i[2]) + DW'(in_sq_i[3]);
    s5_rhh_d = RHHW'($signed(in_res_i[RW-1:RH])) * RHHW'($signed(in_res_i[RW-1:RH]));
    s5_rhl_d = RHLW'($signed(in_res_i[RW-1:RH])) * RHLW'($signed({1'b0, in_res_i[RH-1:0]}));
    s5_rll_d = RLLW'(in_res_i[RH-1:0]) * RLLW'(in_res_i[RH-1:0]);
  end

  always_comb begin
    res2_full  = (RSW'(s5_rhh_q) << (2 * RH)) + (RSW'(s5_rhl_q) << (RH + 1))
               + RSW'(s5_rll_q);
    s6_pc_d[0] = PKW'(thr_i) * PKW'(s5_den_q[K-1:0]);
    s6_pc_d[1] = PKW'(thr_i) * PKW'(s5_den_q[2*K-1:K]);
    s6_pc_d[2] = PKW'(thr_i) * PKW'(s5_den_q[DW-1:2*K]);
  end

  always_comb begin
    s7_rhs_d = (TW'(s6_pc_q[2]) << (2 * K)) + (TW'(s6_pc_q[1]) << K) + TW'(s6_pc_q[0]);
  end

  always_comb begin
    lhs               = CMW'(s7_res2_q) << sic_pkg::FracBits;
    rhs               = CMW'(s7_rhs_q);
    out_d.inlier      = !s7_deg_q && (lhs < rhs);
    out_d.degenerate  = s7_deg_q;
    out_d.last_result = s7_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      s7_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv5) begin
        s5_v_q <= in_valid_i;
      end
      if (adv6) begin
        s6_v_q <= s5_v_q;
      end
      if (adv7) begin
        s7_v_q <= s6_v_q;
      end
      if (adv8) begin
        out_v_q <= s7_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv5 && in_valid_i) begin
      s5_den_q  <= s5_den_d;
      s5_rhh_q  <= s5_rhh_d;
      s5_rhl_q  <= s5_rhl_d;
      s5_rll_q  <= s5_rll_d;
      s5_last_q <= in_last_i;
    end
    if (adv6 && s5_v_q) begin
      s6_res2_q <= res2_full[R2W-1:0];
      s6_pc_q   <= s6_pc_d;
      s6_deg_q  <= (s5_den_q == '0);
      s6_last_q <= s5_last_q;
    end
    if (adv7 && s6_v_q) begin
      s7_rhs_q  <= s7_rhs_d;
      s7_res2_q <= s6_res2_q;
      s7_deg_q  <= s6_deg_q;
      s7_last_q <= s6_last_q;
    end
    if (adv8 && s7_v_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/sampson_inlier_classifier.sv
// An accepted beat passes s1, s2 (sic_front), s3, s4 (sic_norm), s5, s6, s7 and
// out (sic_decide). Throughput: one correspondence per cycle unless the output
// stalls; each of 8 stages holds one item and advances when the next has room.
// Reset clears every pipeline valid bit, loads F with zeros and the threshold
// with 1.0 (Q16.16); the block accepts beats from the first cycle after reset.
module sampson_inlier_classifier #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned COEF_WIDTH  = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sic_pkg::sic_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sic_pkg::sic_out_t               out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sic_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [sic_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned RowW = 3 * COEF_WIDTH;
  localparam int unsigned FXW  = COEF_WIDTH + COORD_WIDTH + 1;
  localparam int unsigned SQW  = 2 * FXW;
  localparam int unsigned RW   = COORD_WIDTH + FXW + 1;

  logic [RowW-1:0]          f_row0_q, f_row1_q, f_row2_q;
  logic [sic_pkg::ThrW-1:0] thr_q;

  logic                     fr_valid, fr_stall;
  logic signed [FXW-1:0]    fr_fx0, fr_fx1, fr_fx2, fr_ft0, fr_ft1;
  logic signed [COORD_WIDTH-1:0] fr_x2, fr_y2;
  logic                     fr_last;

  logic                     nm_valid, nm_stall;
  logic signed [RW-1:0]     nm_res;
  logic [SQW-1:0]           nm_sq [4];
  logic                     nm_last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_row0_q <= '0;
      f_row1_q <= '0;
      f_row2_q <= '0;
      thr_q    <= sic_pkg::ThrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sic_pkg::CfgFRow0:     f_row0_q <= RowW'(cfg_data_i);
        sic_pkg::CfgFRow1:     f_row1_q <= RowW'(cfg_data_i);
        sic_pkg::CfgFRow2:     f_row2_q <= RowW'(cfg_data_i);
        sic_pkg::CfgThreshold: thr_q    <= cfg_data_i[sic_pkg::ThrW-1:0];
        default: begin
        end
      endcase
    end
  end

  sic_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .f_row0_i    (f_row0_q),
    .f_row1_i    (f_row1_q),
    .f_row2_i    (f_row2_q),
    .out_valid_o (fr_valid),
    .out_stall_i (fr_stall),
    .out_fx0_o   (fr_fx0),
    .out_fx1_o   (fr_fx1),
    .out_fx2_o   (fr_fx2),
    .out_ft0_o   (fr_ft0),
    .out_ft1_o   (fr_ft1),
    .out_x2_o    (fr_x2),
    .out_y2_o    (fr_y2),
    .out_last_o  (fr_last)
  );

  sic_norm #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_stall_o  (fr_stall),
    .in_fx0_i    (fr_fx0),
    .in_fx1_i    (fr_fx1),
    .in_fx2_i    (fr_fx2),
    .in_ft0_i    (fr_ft0),
    .in_ft1_i    (fr_ft1),
    .in_x2_i     (fr_x2),
    .in_y2_i     (fr_y2),
    .in_last_i   (fr_last),
    .out_valid_o (nm_valid),
    .out_stall_i (nm_stall),
    .out_res_o   (nm_res),
    .out_sq_o    (nm_sq),
    .out_last_o  (nm_last)
  );

  sic_decide #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (nm_valid),
    .in_stall_o  (nm_stall),
    .in_res_i    (nm_res),
    .in_sq_i     (nm_sq),
    .in_last_i   (nm_last),
    .thr_i       (thr_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_deg_not_inlier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.inlier && out_data_o.degenerate))
    else $error("Degenerate result beat is also marked as an inlier.");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("Input stalled while the output side is free.");

  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("Result beat presented right after reset.");
`endif

endmodule
